// ===== hdl/etf_pkg.sv =====
// Shared types, constants and arithmetic helpers of the escape time fractal iterator.
package etf_pkg;

    // Fixed field widths of the data and configuration ports.
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STEP_W     = 31;
    localparam int unsigned MAXIT_W    = 16;
    localparam int unsigned POWER_W    = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned COUNT_OUT_W = 16;
    // The running count can pass the 16-bit limit by up to four after a late escape.
    localparam int unsigned ITER_W     = MAXIT_W + 1;
    localparam int unsigned PROD_W     = 2 * VALUE_W;
    localparam int unsigned WIDE_W     = PROD_W + 2;

    // Parameter defaults.
    localparam int unsigned DEF_FRAC_BITS  = 28;
    localparam int unsigned DEF_PIXEL_BITS = 10;
    localparam int unsigned DEF_COUNT_BITS = 16;

    // Register reset values.
    localparam logic signed [VALUE_W-1:0] RST_ORIGIN_RE = -32'sd402211955;
    localparam logic signed [VALUE_W-1:0] RST_ORIGIN_IM = -32'sd623432658;
    localparam logic [STEP_W-1:0]         RST_STEP_RE   = 31'd1258291;
    localparam logic [STEP_W-1:0]         RST_STEP_IM   = 31'd1258291;
    localparam logic [MAXIT_W-1:0]        RST_MAX_ITER  = 16'd400;
    localparam logic [POWER_W-1:0]        RST_POWER     = 2'd1;
    localparam logic                      RST_FOLD      = 1'b0;

    // Power mode codes; the unused code behaves as identity.
    localparam logic [POWER_W-1:0] PWR_IDENT  = 2'd0;
    localparam logic [POWER_W-1:0] PWR_SQUARE = 2'd1;
    localparam logic [POWER_W-1:0] PWR_CUBE   = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4,
        CFG_POWER     = 3'd5,
        CFG_FOLD      = 3'd6
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_C_RE,
        S_C_IM,
        S_C_FIN,
        S_CHECK,
        S_ESC0,
        S_ESC1,
        S_ESC2,
        S_FOLD,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_CU0,
        S_CU1,
        S_CU2,
        S_CU3,
        S_CU4,
        S_CU5,
        S_CU6,
        S_ADD,
        S_DONE
    } t_state;

    // Saturate a wide signed value to the 32-bit value range.
    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[VALUE_W-1:0];
        end
    endfunction

    // Absolute value; the most negative value saturates to the most positive.
    function automatic logic signed [VALUE_W-1:0] abs_sat(input logic signed [VALUE_W-1:0] v);
        if (v == 32'sh8000_0000) begin
            return 32'sh7FFF_FFFF;
        end else if (v < 0) begin
            return -v;
        end else begin
            return v;
        end
    endfunction

    // Sign-extend a 64-bit product or a 32-bit value to the accumulator width.
    function automatic logic signed [WIDE_W-1:0] wide_p(input logic signed [PROD_W-1:0] p);
        return {{(WIDE_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic logic signed [WIDE_W-1:0] wide_v(input logic signed [VALUE_W-1:0] v);
        return {{(WIDE_W-VALUE_W){v[VALUE_W-1]}}, v};
    endfunction

endpackage

// ===== hdl/escape_time_fractal_iterator_unit.sv =====
// Escape time fractal iterator: one pixel in, iteration count and final z out.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ----------------------------------------
//  in        input      i_in_valid / o_in_stall   i_pixel_x, i_pixel_y
//  out       output     o_out_valid / i_out_stall o_iter_count, o_inside_res, o_final_re/im
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One 32x32 signed multiplier with a registered product is shared by every step under
// the sequencer. After an item is accepted, the sequencer forms c, then runs each iteration
// through the escape test (only until the first escape), the fold, the power steps and the
// add of c. A last limit check and the output load follow, then the sequencer goes idle.
// The count of iterations is the limit, or the escape index plus five.
// Synchronous active-low reset restores the configuration registers and the state, and empties the output register.
// The input stalls while an item is in work; a stalled result holds the last state.
module escape_time_fractal_iterator_unit #(
    parameter int unsigned FRAC_BITS  = etf_pkg::DEF_FRAC_BITS,
    parameter int unsigned PIXEL_BITS = etf_pkg::DEF_PIXEL_BITS,
    parameter int unsigned COUNT_BITS = etf_pkg::DEF_COUNT_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [etf_pkg::VALUE_W-1:0]           i_cfg_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [PIXEL_BITS-1:0]                 i_pixel_x,
    input  logic [PIXEL_BITS-1:0]                 i_pixel_y,
    // Output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [etf_pkg::COUNT_OUT_W-1:0]       o_iter_count,
    output logic                                  o_inside_res,
    output logic signed [etf_pkg::VALUE_W-1:0]    o_final_re,
    output logic signed [etf_pkg::VALUE_W-1:0]    o_final_im
);

    localparam int unsigned VW = etf_pkg::VALUE_W;
    localparam int unsigned WW = etf_pkg::WIDE_W;
    localparam int unsigned IW = etf_pkg::ITER_W;
    localparam int unsigned CNT_CMP_W = 33;
    // Escape is only reachable when the threshold fits in the product range.
    localparam bit ESC_ON = (2 * FRAC_BITS + 2 < 64);
    localparam logic signed [WW-1:0] ESC_LIMIT = 66'sd4 <<< (2 * FRAC_BITS);
    localparam logic [CNT_CMP_W-1:0] CNT_MAX =
        (CNT_CMP_W'(1) << COUNT_BITS) - CNT_CMP_W'(1);

    // Configuration registers.
    logic signed [VW-1:0]               r_origin_re;
    logic signed [VW-1:0]               r_origin_im;
    logic [etf_pkg::STEP_W-1:0]         r_step_re;
    logic [etf_pkg::STEP_W-1:0]         r_step_im;
    logic [etf_pkg::MAXIT_W-1:0]        r_max_iter;
    logic [etf_pkg::POWER_W-1:0]        r_power;
    logic                               r_fold;

    // Sequencer and datapath registers.
    etf_pkg::t_state                    r_state;
    etf_pkg::t_state                    n_state;
    logic [PIXEL_BITS-1:0]              r_px;
    logic [PIXEL_BITS-1:0]              r_py;
    logic signed [VW-1:0]               r_c_re;
    logic signed [VW-1:0]               r_c_im;
    logic signed [VW-1:0]               r_z_re;
    logic signed [VW-1:0]               r_z_im;
    logic signed [VW-1:0]               r_a;
    logic signed [VW-1:0]               r_b;
    logic signed [VW-1:0]               r_t1;
    logic signed [VW-1:0]               r_t2;
    logic signed [WW-1:0]               r_acc;
    logic signed [etf_pkg::PROD_W-1:0]  r_prod;
    logic [IW-1:0]                      r_count;
    logic [IW-1:0]                      r_stop;
    logic                               r_late;

    // Output register.
    logic                               r_out_valid;
    logic [etf_pkg::COUNT_OUT_W-1:0]    r_out_count;
    logic                               r_out_inside;
    logic signed [VW-1:0]               r_out_re;
    logic signed [VW-1:0]               r_out_im;

    logic signed [VW-1:0]               s_mul_x;
    logic signed [VW-1:0]               s_mul_y;
    logic                               s_in_accept;
    logic                               s_out_load;
    logic [CNT_CMP_W-1:0]               s_count_ext;
    logic [CNT_CMP_W-1:0]               s_count_sat;
    logic signed [WW-1:0]               s_prod_w;
    logic signed [WW-1:0]               s_mag;

    assign s_in_accept = i_in_valid && !o_in_stall;
    assign s_out_load  = (r_state == etf_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign s_prod_w    = etf_pkg::wide_p(r_prod);
    assign s_mag       = r_acc + s_prod_w;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= etf_pkg::RST_ORIGIN_RE;
            r_origin_im <= etf_pkg::RST_ORIGIN_IM;
            r_step_re   <= etf_pkg::RST_STEP_RE;
            r_step_im   <= etf_pkg::RST_STEP_IM;
            r_max_iter  <= etf_pkg::RST_MAX_ITER;
            r_power     <= etf_pkg::RST_POWER;
            r_fold      <= etf_pkg::RST_FOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                etf_pkg::CFG_ORIGIN_RE: r_origin_re <= i_cfg_data;
                etf_pkg::CFG_ORIGIN_IM: r_origin_im <= i_cfg_data;
                etf_pkg::CFG_STEP_RE:   r_step_re   <= i_cfg_data[etf_pkg::STEP_W-1:0];
                etf_pkg::CFG_STEP_IM:   r_step_im   <= i_cfg_data[etf_pkg::STEP_W-1:0];
                etf_pkg::CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[etf_pkg::MAXIT_W-1:0];
                etf_pkg::CFG_POWER:     r_power     <= i_cfg_data[etf_pkg::POWER_W-1:0];
                etf_pkg::CFG_FOLD:      r_fold      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            etf_pkg::S_IDLE:  if (i_in_valid) n_state = etf_pkg::S_C_RE;
            etf_pkg::S_C_RE:  n_state = etf_pkg::S_C_IM;
            etf_pkg::S_C_IM:  n_state = etf_pkg::S_C_FIN;
            etf_pkg::S_C_FIN: n_state = etf_pkg::S_CHECK;
            etf_pkg::S_CHECK: begin
                if (r_count >= r_stop) begin
                    n_state = etf_pkg::S_DONE;
                end else if (!r_late) begin
                    n_state = etf_pkg::S_ESC0;
                end else begin
                    n_state = etf_pkg::S_FOLD;
                end
            end
            etf_pkg::S_ESC0:  n_state = etf_pkg::S_ESC1;
            etf_pkg::S_ESC1:  n_state = etf_pkg::S_ESC2;
            etf_pkg::S_ESC2:  n_state = etf_pkg::S_FOLD;
            etf_pkg::S_FOLD: begin
                if (r_power == etf_pkg::PWR_SQUARE) begin
                    n_state = etf_pkg::S_SQ0;
                end else if (r_power == etf_pkg::PWR_CUBE) begin
                    n_state = etf_pkg::S_CU0;
                end else begin
                    n_state = etf_pkg::S_ADD;
                end
            end
            etf_pkg::S_SQ0:   n_state = etf_pkg::S_SQ1;
            etf_pkg::S_SQ1:   n_state = etf_pkg::S_SQ2;
            etf_pkg::S_SQ2:   n_state = etf_pkg::S_SQ3;
            etf_pkg::S_SQ3:   n_state = etf_pkg::S_ADD;
            etf_pkg::S_CU0:   n_state = etf_pkg::S_CU1;
            etf_pkg::S_CU1:   n_state = etf_pkg::S_CU2;
            etf_pkg::S_CU2:   n_state = etf_pkg::S_CU3;
            etf_pkg::S_CU3:   n_state = etf_pkg::S_CU4;
            etf_pkg::S_CU4:   n_state = etf_pkg::S_CU5;
            etf_pkg::S_CU5:   n_state = etf_pkg::S_CU6;
            etf_pkg::S_CU6:   n_state = etf_pkg::S_ADD;
            etf_pkg::S_ADD:   n_state = etf_pkg::S_CHECK;
            etf_pkg::S_DONE:  if (s_out_load) n_state = etf_pkg::S_IDLE;
            default:          n_state = etf_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: input stall and the operands of the shared multiplier.
    always_comb begin
        o_in_stall = (r_state != etf_pkg::S_IDLE);
        s_mul_x    = '0;
        s_mul_y    = '0;
        case (r_state)
            etf_pkg::S_C_RE: begin
                s_mul_x = $signed({1'b0, r_step_re});
                s_mul_y = $signed({{(VW-PIXEL_BITS){1'b0}}, r_px});
            end
            etf_pkg::S_C_IM: begin
                s_mul_x = $signed({1'b0, r_step_im});
                s_mul_y = $signed({{(VW-PIXEL_BITS){1'b0}}, r_py});
            end
            etf_pkg::S_ESC0: begin
                s_mul_x = r_z_re;
                s_mul_y = r_z_re;
            end
            etf_pkg::S_ESC1: begin
                s_mul_x = r_z_im;
                s_mul_y = r_z_im;
            end
            etf_pkg::S_SQ0, etf_pkg::S_CU0: begin
                s_mul_x = r_a;
                s_mul_y = r_a;
            end
            etf_pkg::S_SQ1, etf_pkg::S_CU1: begin
                s_mul_x = r_b;
                s_mul_y = r_b;
            end
            etf_pkg::S_SQ2: begin
                s_mul_x = r_a;
                s_mul_y = r_b;
            end
            etf_pkg::S_CU4: begin
                s_mul_x = r_a;
                s_mul_y = r_t1;
            end
            etf_pkg::S_CU5: begin
                s_mul_x = r_b;
                s_mul_y = r_t2;
            end
            default: begin
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        r_prod <= s_mul_x * s_mul_y;
    end

    // Datapath: c, escape test, fold, power steps and the add of c.
    always_ff @(posedge i_clk) begin
        case (r_state)
            etf_pkg::S_IDLE: begin
                if (s_in_accept) begin
                    r_px    <= i_pixel_x;
                    r_py    <= i_pixel_y;
                    r_count <= '0;
                    r_late  <= 1'b0;
                    r_stop  <= {1'b0, r_max_iter};
                end
            end
            etf_pkg::S_C_IM: begin
                r_c_re <= etf_pkg::sat32(etf_pkg::wide_v(r_origin_re) + s_prod_w);
                r_z_re <= etf_pkg::sat32(etf_pkg::wide_v(r_origin_re) + s_prod_w);
            end
            etf_pkg::S_C_FIN: begin
                r_c_im <= etf_pkg::sat32(etf_pkg::wide_v(r_origin_im) + s_prod_w);
                r_z_im <= etf_pkg::sat32(etf_pkg::wide_v(r_origin_im) + s_prod_w);
            end
            etf_pkg::S_ESC1: begin
                r_acc <= s_prod_w;
            end
            etf_pkg::S_ESC2: begin
                // First time |z|^2 exceeds four: five more iterations from here.
                if (ESC_ON && (s_mag > ESC_LIMIT)) begin
                    r_late <= 1'b1;
                    r_stop <= r_count + IW'(5);
                end
            end
            etf_pkg::S_FOLD: begin
                r_a <= r_fold ? etf_pkg::abs_sat(r_z_re) : r_z_re;
                r_b <= r_fold ? etf_pkg::abs_sat(r_z_im) : r_z_im;
            end
            etf_pkg::S_SQ1: begin
                r_acc <= s_prod_w;
            end
            etf_pkg::S_SQ2: begin
                r_acc <= r_acc - s_prod_w;
            end
            etf_pkg::S_SQ3: begin
                r_a <= etf_pkg::sat32(r_acc >>> FRAC_BITS);
                r_b <= etf_pkg::sat32(s_prod_w >>> (FRAC_BITS - 1));
            end
            etf_pkg::S_CU1: begin
                r_t1 <= etf_pkg::sat32(s_prod_w >>> FRAC_BITS);
            end
            etf_pkg::S_CU2: begin
                r_t2 <= etf_pkg::sat32(s_prod_w >>> FRAC_BITS);
            end
            etf_pkg::S_CU3: begin
                // t1 holds a^2 and t2 holds b^2 on entry.
                r_t1 <= etf_pkg::sat32(etf_pkg::wide_v(r_t1) - 3 * etf_pkg::wide_v(r_t2));
                r_t2 <= etf_pkg::sat32(3 * etf_pkg::wide_v(r_t1) - etf_pkg::wide_v(r_t2));
            end
            etf_pkg::S_CU5: begin
                r_a <= etf_pkg::sat32(s_prod_w >>> FRAC_BITS);
            end
            etf_pkg::S_CU6: begin
                r_b <= etf_pkg::sat32(s_prod_w >>> FRAC_BITS);
            end
            etf_pkg::S_ADD: begin
                r_z_re  <= etf_pkg::sat32(etf_pkg::wide_v(r_a) + etf_pkg::wide_v(r_c_re));
                r_z_im  <= etf_pkg::sat32(etf_pkg::wide_v(r_b) + etf_pkg::wide_v(r_c_im));
                r_count <= r_count + IW'(1);
            end
            default: begin
            end
        endcase
    end

    // Reported count saturates at the configured count width.
    assign s_count_ext = {{(CNT_CMP_W-IW){1'b0}}, r_count};
    assign s_count_sat = (s_count_ext > CNT_MAX) ? CNT_MAX : s_count_ext;

    // Output register: loads when empty or being emptied in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out_count  <= s_count_sat[etf_pkg::COUNT_OUT_W-1:0];
            r_out_inside <= (r_count == {1'b0, r_max_iter});
            r_out_re     <= r_z_re;
            r_out_im     <= r_z_im;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_iter_count = r_out_count;
    assign o_inside_res = r_out_inside;
    assign o_final_re   = r_out_re;
    assign o_final_im   = r_out_im;

endmodule

// ===== tb/sv/tb_escape_time_fractal_iterator_unit.sv =====
// Testbench for the escape time fractal iterator: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_escape_time_fractal_iterator_unit;

    localparam int FRAC = etf_pkg::DEF_FRAC_BITS;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam logic [etf_pkg::POWER_W-1:0] PWR_SPARE = 2'd3;
    localparam logic [etf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SETTLE = 16;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [etf_pkg::DEF_PIXEL_BITS-1:0] px;
        logic [etf_pkg::DEF_PIXEL_BITS-1:0] py;
    } t_pixel_req;

    typedef struct packed {
        logic [etf_pkg::COUNT_OUT_W-1:0]     count;
        logic                                in_set;
        logic signed [etf_pkg::VALUE_W-1:0]  re;
        logic signed [etf_pkg::VALUE_W-1:0]  im;
    } t_pixel_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [etf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [etf_pkg::VALUE_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [etf_pkg::DEF_PIXEL_BITS-1:0] i_pixel_x = '0;
    logic [etf_pkg::DEF_PIXEL_BITS-1:0] i_pixel_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [etf_pkg::COUNT_OUT_W-1:0] o_iter_count;
    logic o_inside_res;
    logic signed [etf_pkg::VALUE_W-1:0] o_final_re;
    logic signed [etf_pkg::VALUE_W-1:0] o_final_im;

    // Shadow copy of the configuration registers.
    logic signed [etf_pkg::VALUE_W-1:0] cfg_origin_re = etf_pkg::RST_ORIGIN_RE;
    logic signed [etf_pkg::VALUE_W-1:0] cfg_origin_im = etf_pkg::RST_ORIGIN_IM;
    logic [etf_pkg::STEP_W-1:0] cfg_step_re = etf_pkg::RST_STEP_RE;
    logic [etf_pkg::STEP_W-1:0] cfg_step_im = etf_pkg::RST_STEP_IM;
    logic [etf_pkg::MAXIT_W-1:0] cfg_max_iter = etf_pkg::RST_MAX_ITER;
    logic [etf_pkg::POWER_W-1:0] cfg_power = etf_pkg::RST_POWER;
    logic cfg_fold = etf_pkg::RST_FOLD;

    t_pixel_req pixel_backlog[$];
    t_pixel_result expected_pixels[$];
    logic in_fire = 1'b0;
    logic rx_took = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int n_fail = 0;

    escape_time_fractal_iterator_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_iter_count (o_iter_count),
        .o_inside_res (o_inside_res),
        .o_final_re   (o_final_re),
        .o_final_im   (o_final_im)
    );

    always #5 i_clk = ~i_clk;

    // Clamp to the signed 32-bit value range.
    function automatic longint clip32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Iterate one pixel under the current register copy and form its result.
    function automatic t_pixel_result escape_pixel(logic [etf_pkg::DEF_PIXEL_BITS-1:0] px,
                                                   logic [etf_pkg::DEF_PIXEL_BITS-1:0] py);
        longint org_re, org_im, col, row, cr, ci, zr, zi, a, b, a2, b2;
        logic [63:0] sq_re, sq_im;
        int unsigned count, stop;
        bit late;
        t_pixel_result res;
        org_re = longint'(cfg_origin_re);
        org_im = longint'(cfg_origin_im);
        col = longint'(px);
        row = longint'(py);
        cr = clip32(org_re + col * longint'(cfg_step_re));
        ci = clip32(org_im + row * longint'(cfg_step_im));
        zr = cr;
        zi = ci;
        count = 0;
        stop = 32'(cfg_max_iter);
        late = 1'b0;
        while (count < stop) begin
            // The first escape shortens the run to five more iterations.
            sq_re = zr * zr;
            sq_im = zi * zi;
            if (!late && (sq_re + sq_im > (64'd4 << (2 * FRAC)))) begin
                late = 1'b1;
                stop = count + 5;
            end
            if (cfg_fold) begin
                if (zr < 0) zr = clip32(-zr);
                if (zi < 0) zi = clip32(-zi);
            end
            a = zr;
            b = zi;
            case (cfg_power)
                etf_pkg::PWR_SQUARE: begin
                    zr = clip32((a * a - b * b) >>> FRAC);
                    zi = clip32((a * b) >>> (FRAC - 1));
                end
                etf_pkg::PWR_CUBE: begin
                    a2 = clip32((a * a) >>> FRAC);
                    b2 = clip32((b * b) >>> FRAC);
                    zr = clip32((a * clip32(a2 - 3 * b2)) >>> FRAC);
                    zi = clip32((b * clip32(3 * a2 - b2)) >>> FRAC);
                end
                default: ;
            endcase
            zr = clip32(zr + cr);
            zi = clip32(zi + ci);
            count++;
        end
        res.count = (count > 65535) ? 16'hFFFF : count[15:0];
        res.in_set = (count == cfg_max_iter);
        res.re = zr[31:0];
        res.im = zi[31:0];
        return res;
    endfunction

    // Input handshake and result channel, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_pixel_result want, got;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        rx_took <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_iter_count, o_inside_res, o_final_re, o_final_im};
            if (expected_pixels.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result: count %0d inside %0d re %0d im %0d",
                             got.count, got.in_set, got.re, got.im);
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: count %0d/%0d inside %0d/%0d re %0d/%0d im %0d/%0d",
                                 want.count, got.count, want.in_set, got.in_set,
                                 want.re, got.re, want.im, got.im);
                end
            end
        end
    end

    // Pixel driver: predicts each accepted item, then presents the next after a gap.
    always @(negedge i_clk) begin
        logic next_valid;
        t_pixel_req pend;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (in_fire) begin
                expected_pixels = {expected_pixels, escape_pixel(i_pixel_x, i_pixel_y)};
                next_valid = 1'b0;
                if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pixel_backlog.size() != 0) begin
                    pend = pixel_backlog.pop_front();
                    i_pixel_x <= pend.px;
                    i_pixel_y <= pend.py;
                    next_valid = 1'b1;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Result receiver: stalls each visible result for a random wait, with no wait in burst phases.
    always @(negedge i_clk) begin
        if (rx_took) begin
            if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
        end
        if (i_rst_n && o_out_valid && rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Write one register and update the shadow copy.
    task automatic cfg_write(logic [etf_pkg::CFG_IDX_W-1:0] idx,
                             logic [etf_pkg::VALUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            etf_pkg::CFG_ORIGIN_RE: cfg_origin_re = data;
            etf_pkg::CFG_ORIGIN_IM: cfg_origin_im = data;
            etf_pkg::CFG_STEP_RE:   cfg_step_re = data[etf_pkg::STEP_W-1:0];
            etf_pkg::CFG_STEP_IM:   cfg_step_im = data[etf_pkg::STEP_W-1:0];
            etf_pkg::CFG_MAX_ITER:  cfg_max_iter = data[etf_pkg::MAXIT_W-1:0];
            etf_pkg::CFG_POWER:     cfg_power = data[etf_pkg::POWER_W-1:0];
            etf_pkg::CFG_FOLD:      cfg_fold = data[0];
            default: ;
        endcase
    endtask

    // Program all registers, then release the write enable.
    task automatic setting(logic [31:0] ore, logic [31:0] oim, logic [31:0] sre,
                           logic [31:0] sim, logic [31:0] lim, logic [31:0] pwr,
                           logic [31:0] fold);
        cfg_write(etf_pkg::CFG_ORIGIN_RE, ore);
        cfg_write(etf_pkg::CFG_ORIGIN_IM, oim);
        cfg_write(etf_pkg::CFG_STEP_RE, sre);
        cfg_write(etf_pkg::CFG_STEP_IM, sim);
        cfg_write(etf_pkg::CFG_MAX_ITER, lim);
        cfg_write(etf_pkg::CFG_POWER, pwr);
        cfg_write(etf_pkg::CFG_FOLD, fold);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every item is sent and every result is back, then let the block settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pixel_backlog.size() != 0 || i_in_valid || expected_pixels.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic queue_pixel(int px, int py);
        t_pixel_req r;
        r.px = px[etf_pkg::DEF_PIXEL_BITS-1:0];
        r.py = py[etf_pkg::DEF_PIXEL_BITS-1:0];
        pixel_backlog = {pixel_backlog, r};
    endtask

    initial begin
        int sent, n, pick;
        bit noisy;
        logic [31:0] ore, oim, sre, sim, lim, pwr, fold;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: corners, a point near the origin and a point near the real axis.
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        queue_pixel(320, 496);
        queue_pixel(200, 500);
        drain();

        // Saturated c, largest step, folded cube and the top iteration limit.
        setting(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF,
                32'(etf_pkg::PWR_CUBE), 1);
        queue_pixel(1023, 0);
        queue_pixel(0, 1023);
        drain();

        // Zero limit with the unused power code: no iteration runs.
        setting(32'h0400_0000, 32'h0400_0000, 32'h0002_0000, 32'h0002_0000, 0,
                32'(PWR_SPARE), 0);
        queue_pixel(5, 7);
        queue_pixel(1023, 1023);
        drain();

        // Single iteration, identity power.
        setting(-32'sd134217728, 32'h0, 32'h0002_0000, 32'h0002_0000, 1,
                32'(etf_pkg::PWR_IDENT), 0);
        queue_pixel(3, 900);
        queue_pixel(1000, 17);
        drain();

        // Unused power code acts as identity over a longer run.
        setting(-32'sd26843545, 32'h0100_0000, 32'h0000_4000, 32'h0000_4000, 20,
                32'(PWR_SPARE), 0);
        queue_pixel(10, 20);
        queue_pixel(600, 300);
        drain();

        // Limit 65530 with an immediate escape; stray write to the spare index.
        setting(32'd671088640, 32'h0, 32'h0, 32'h0, 65530, 32'(etf_pkg::PWR_SQUARE), 0);
        cfg_write(CFG_UNUSED, 32'hA5A5_A5A5);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        queue_pixel(512, 512);
        drain();

        // Folded square near the edge of the fractal.
        setting(-32'sd483183821, -32'sd21474836, 32'h0000_4000, 32'h0000_4000, 64,
                32'(etf_pkg::PWR_SQUARE), 1);
        queue_pixel(0, 0);
        queue_pixel(700, 300);
        queue_pixel(1023, 1023);
        drain();

        // Random phases: mostly views over the interesting region, some noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            noisy = ($urandom_range(0, 4) == 0);
            if (noisy) begin
                ore = $urandom();
                oim = $urandom();
                sre = $urandom();
                sim = $urandom();
                pick = $urandom_range(0, 3);
                if (pick == 0) sre = 32'h0;
                if (pick == 1) sim = 32'hFFFF_FFFF;
            end else begin
                ore = $urandom_range(0, 805306368) - 32'd671088640;
                oim = $urandom_range(0, 536870912) - 32'd402653184;
                sre = $urandom_range(0, 524288);
                sim = $urandom_range(0, 524288);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) lim = 0;
            else if (pick == 1) lim = 1;
            else if (pick == 2) lim = $urandom_range(100, 400);
            else lim = $urandom_range(2, 32);
            pick = $urandom_range(0, 7);
            if (pick == 0) pwr = 32'(etf_pkg::PWR_IDENT);
            else if (pick == 1) pwr = 32'(PWR_SPARE);
            else if (pick <= 4) pwr = 32'(etf_pkg::PWR_SQUARE);
            else pwr = 32'(etf_pkg::PWR_CUBE);
            fold = 32'($urandom_range(0, 3) == 0);
            // Unused upper data bits must not matter.
            if (noisy) begin
                lim[31:16] = 16'($urandom());
                pwr[31:2] = 30'($urandom());
                fold[31:1] = 31'($urandom());
            end
            setting(ore, oim, sre, sim, lim, pwr, fold);
            n = (lim > 32) ? 4 : $urandom_range(10, 40);
            repeat (n) queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            sent += n;
            drain();
        end

        if (n_fail == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #200000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
